/* src/bcddiv_pkg.sv */
`default_nettype none
package bcddiv_pkg;
    localparam int Digits = 30;
    localparam int DigitBits = 4;
    localparam int ManBits = Digits * DigitBits;
    localparam int RemDigits = Digits + 1;
    localparam int RemBits = RemDigits * DigitBits;
    localparam int QuotSteps = Digits + 2;
    localparam int DigCntBits = $clog2(QuotSteps + 1);
    localparam int ExpBits = 18;
    localparam int WideExpBits = 21;
    localparam int OutExpBits = 19;
    localparam int ExpLimit = 99999;
    localparam int ExpFieldMax = 262143;
    localparam int ExpFieldMin = -262144;
    localparam logic [DigitBits-1:0] RoundDigit = 4'd5;
    localparam int InBits = 2 + 4 * 60 + 2 * ExpBits;
    localparam int InBytes = (InBits + 7) / 8;
    localparam int OutBits = 1 + 2 * 60 + OutExpBits + 2;
    localparam int OutBytes = (OutBits + 7) / 8;

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // clamp nibble to a decimal digit
    function automatic logic [DigitBits-1:0] clamp_digit(input logic [DigitBits-1:0] n);
        clamp_digit = (n > 4'd9) ? 4'd9 : n;
    endfunction
endpackage
`default_nettype wire

/* src/bcddiv_digit_alu.sv */
`default_nettype none
// one BCD digit of a compare or subtract chain, least significant first
module bcddiv_digit_alu
    import bcddiv_pkg::*;
(
    input  wire logic [DigitBits-1:0] a,
    input  wire logic [DigitBits-1:0] b,
    input  wire logic                 borrow_in,
    output logic [DigitBits-1:0]      diff,
    output logic                      borrow_out
);
    logic [DigitBits:0] raw;

    always_comb
    begin
        raw = {1'b0, a} - {1'b0, b} - {{DigitBits{1'b0}}, borrow_in};
        borrow_out = raw[DigitBits];
        diff = borrow_out ? (raw[DigitBits-1:0] + 4'd10) : raw[DigitBits-1:0];
    end
endmodule
`default_nettype wire

/* src/bcd_decimal_float_divider.sv */
`default_nettype none
// channel | dir | tdata fields (lsb first)
// s_axis  | in  | dividend_negative, dividend_digits_high, dividend_digits_low,
//         |     | dividend_exponent, divisor_negative, divisor_digits_high,
//         |     | divisor_digits_low, divisor_exponent
// m_axis  | out | quotient_negative, quotient_digits_high, quotient_digits_low,
//         |     | quotient_exponent, status
// one item at a time; each trial subtract walks the 31-digit remainder one
// digit per cycle through a single BCD digit subtractor (up to 10 trials per
// quotient digit, 32 quotient digits), plus leading-zero stripping of each
// operand and a rippled rounding carry. The output register holds a result
// until taken while s_axis_tready stays low. rst_n clears control state.
module bcd_decimal_float_divider
    import bcddiv_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [InBytes*8-1:0]   s_axis_tdata,   // see table above
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OutBytes*8-1:0]       m_axis_tdata    // see table above
);
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_NORMA = 9'b000000010,
        ST_NORMB = 9'b000000100,
        ST_TRIAL = 9'b000001000,
        ST_SUB   = 9'b000010000,
        ST_SHIFT = 9'b000100000,
        ST_ROUND = 9'b001000000,
        ST_FINAL = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [ManBits-1:0] a_reg, a_next;
    logic [RemBits-1:0] rem_reg, rem_next, dv_reg, dv_next, acc_reg, acc_next;
    logic [(QuotSteps)*DigitBits-1:0] q_reg, q_next;
    logic [WideExpBits-1:0] exp_reg, exp_next;
    logic neg_reg, neg_next, bor_reg, bor_next;
    logic [DigCntBits-1:0] cnt_reg, cnt_next, step_reg, step_next;
    logic [DigitBits-1:0] dig_reg, dig_next;
    logic [OutBytes*8-1:0] out_reg, out_next;
    logic [DigitBits-1:0] alu_diff;
    logic alu_bout;

    // unpack input fields
    logic [59:0] a_hi, a_lo, b_hi, b_lo;
    logic [ExpBits-1:0] ea, eb;
    assign a_hi = s_axis_tdata[60:1];
    assign a_lo = s_axis_tdata[120:61];
    assign ea   = s_axis_tdata[138:121];
    assign b_hi = s_axis_tdata[199:140];
    assign b_lo = s_axis_tdata[259:200];
    assign eb   = s_axis_tdata[277:260];

    // digit subtractor works on the lowest digit of the rotating registers
    bcddiv_digit_alu u_alu (
        .a(rem_reg[DigitBits-1:0]),
        .b(dv_reg[DigitBits-1:0]),
        .borrow_in(bor_reg),
        .diff(alu_diff),
        .borrow_out(alu_bout)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_reg;

    logic [ManBits-1:0] ina, inb;
    logic [WideExpBits-1:0] fexp;
    logic [OutExpBits-1:0] sat_exp;
    logic [ManBits-1:0] mant;
    logic [DigitBits-1:0] rd;

    always_comb
    begin
        state_next = state_reg;
        a_next = a_reg; rem_next = rem_reg; dv_next = dv_reg; acc_next = acc_reg;
        q_next = q_reg; exp_next = exp_reg; neg_next = neg_reg; bor_next = bor_reg;
        cnt_next = cnt_reg; step_next = step_reg; dig_next = dig_reg; out_next = out_reg;
        ina = '0; inb = '0; fexp = '0; sat_exp = '0; mant = '0; rd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    for (int k = 0; k < Digits; k++)
                    begin
                        ina[(Digits-1-k)*4 +: 4] = clamp_digit((k < 15) ?
                            a_hi[(14-k)*4 +: 4] : a_lo[(29-k)*4 +: 4]);
                        inb[(Digits-1-k)*4 +: 4] = clamp_digit((k < 15) ?
                            b_hi[(14-k)*4 +: 4] : b_lo[(29-k)*4 +: 4]);
                    end
                    a_next = ina;
                    dv_next = {4'd0, inb};
                    neg_next = s_axis_tdata[0] ^ s_axis_tdata[139];
                    exp_next = WideExpBits'($signed(ea)) - WideExpBits'($signed(eb))
                        + WideExpBits'(1);
                    cnt_next = '0;
                    state_next = ST_NORMB;
                end
            end
            // strip divisor leading zeros, one digit per cycle
            ST_NORMB:
            begin
                if (dv_reg[ManBits-1 -: 4] != 4'd0)
                begin
                    cnt_next = '0; state_next = ST_NORMA;
                end
                else if (cnt_reg == DigCntBits'(Digits - 1))
                begin
                    out_next = '0;
                    out_next[OutBits-1 -: 2] = STATUS_DIV_ZERO;
                    state_next = ST_OUT;
                end
                else
                begin
                    dv_next = {4'd0, dv_reg[ManBits-5:0], 4'd0};
                    exp_next = exp_reg + WideExpBits'(1);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_NORMA:
            begin
                if (a_reg[ManBits-1 -: 4] != 4'd0)
                begin
                    rem_next = {4'd0, a_reg};
                    q_next = '0; step_next = '0; dig_next = '0;
                    cnt_next = '0; bor_next = 1'b0; acc_next = '0;
                    state_next = ST_TRIAL;
                end
                else if (cnt_reg == DigCntBits'(Digits - 1))
                begin
                    out_next = '0;
                    out_next[0] = neg_reg;
                    out_next[121 +: OutExpBits] = OutExpBits'(1);
                    state_next = ST_OUT;
                end
                else
                begin
                    a_next = {a_reg[ManBits-5:0], 4'd0};
                    exp_next = exp_reg - WideExpBits'(1);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            // trial subtract, rotating both words one digit per cycle
            ST_TRIAL:
            begin
                acc_next = {alu_diff, acc_reg[RemBits-1:4]};
                rem_next = {rem_reg[3:0], rem_reg[RemBits-1:4]};
                dv_next = {dv_reg[3:0], dv_reg[RemBits-1:4]};
                bor_next = alu_bout;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DigCntBits'(RemDigits - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_SUB;
                end
            end
            // final borrow says whether the trial fits
            ST_SUB:
            begin
                bor_next = 1'b0;
                if (!bor_reg && dig_reg != 4'd9)
                begin
                    rem_next = acc_reg;
                    dig_next = dig_reg + 4'd1;
                    state_next = ST_TRIAL;
                end
                else
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                q_next = {q_reg[QuotSteps*4-5:0], dig_reg};
                rem_next = {rem_reg[RemBits-5:0], 4'd0};
                dig_next = '0;
                step_next = step_reg + 1'b1;
                if (step_reg == DigCntBits'(QuotSteps - 1))
                begin
                    if (q_reg[QuotSteps*4-5 -: 4] == 4'd0)
                    begin
                        acc_next = {q_reg[ManBits-1:0], dig_reg};
                        exp_next = exp_reg - WideExpBits'(1);
                    end
                    else
                        acc_next = q_reg[RemBits-1:0];
                    cnt_next = '0;
                    state_next = ST_ROUND;
                end
                else
                    state_next = ST_TRIAL;
            end
            // round: acc holds m digits plus round digit at the bottom
            ST_ROUND:
            begin
                rd = acc_reg[3:0];
                bor_next = (rd >= RoundDigit);
                rem_next = {4'd0, acc_reg[RemBits-1:4]};
                cnt_next = '0;
                acc_next = '0;
                state_next = ST_FINAL;
            end
            // ripple the carry one digit per cycle, rotating into acc
            ST_FINAL:
            begin
                if (cnt_reg == DigCntBits'(Digits))
                begin
                    mant = acc_reg[RemBits-1:4];
                    fexp = exp_reg;
                    if (bor_reg)
                    begin
                        mant[ManBits-1 -: 4] = 4'd1;
                        fexp = exp_reg + WideExpBits'(1);
                    end
                    if ($signed(fexp) > ExpFieldMax)
                        sat_exp = OutExpBits'(ExpFieldMax);
                    else if ($signed(fexp) < ExpFieldMin)
                        sat_exp = OutExpBits'(ExpFieldMin);
                    else
                        sat_exp = fexp[OutExpBits-1:0];
                    out_next = '0;
                    out_next[0] = neg_reg;
                    out_next[1 +: 60] = mant[ManBits-1 -: 60];
                    out_next[61 +: 60] = mant[59:0];
                    out_next[121 +: OutExpBits] = sat_exp;
                    out_next[OutBits-1 -: 2] =
                        ($signed(fexp) > ExpLimit || $signed(fexp) < -ExpLimit) ?
                        STATUS_RANGE : STATUS_OK;
                    state_next = ST_OUT;
                end
                else
                begin
                    rd = rem_reg[3:0];
                    if (bor_reg && rd == 4'd9)
                        rd = 4'd0;
                    else if (bor_reg)
                    begin
                        rd = rd + 4'd1;
                        bor_next = 1'b0;
                    end
                    acc_next = {rd, acc_reg[RemBits-1:4]};
                    rem_next = {4'd0, rem_reg[RemBits-1:4]};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            step_reg <= '0;
            bor_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            step_reg <= step_next;
            bor_reg <= bor_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next; rem_reg <= rem_next; dv_reg <= dv_next; acc_reg <= acc_next;
        q_reg <= q_next; exp_reg <= exp_next; neg_reg <= neg_next;
        dig_reg <= dig_next; out_reg <= out_next;
    end
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none
module testbench;
    import bcddiv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               neg;
        logic [59:0]        hi;
        logic [59:0]        lo;
        logic signed [17:0] exp;
    } operand_t;

    typedef struct packed {
        operand_t dividend;
        operand_t divisor;
    } division_t;

    typedef struct packed {
        logic        neg;
        logic [59:0] hi;
        logic [59:0] lo;
        logic [18:0] exp;
        status_t     status;
    } quotient_t;

    typedef struct {
        division_t in;
        bit        known;
        quotient_t res;
    } stim_row_t;

    localparam int RandomItems = 1400;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [InBytes*8-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OutBytes*8-1:0] m_axis_tdata;

    quotient_t pending_quotients[$];
    stim_row_t directed_rows[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        error_count;
    int        quotient_count;
    int        div_zero_count;
    int        range_count;

    bcd_decimal_float_divider uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mantissa slot k of a 30-digit operand, nibbles above nine read as nine
    function automatic int digit_at(logic [59:0] hi, logic [59:0] lo, int k);
        logic [3:0] nib;
        nib = (k < 15) ? hi[(14 - k) * 4 +: 4] : lo[(29 - k) * 4 +: 4];
        return (nib > 4'd9) ? 9 : int'(nib);
    endfunction

    // predicted quotient by restoring digit-by-digit long division
    function automatic quotient_t divide_decimal(division_t d);
        int        a[Digits];
        int        b[Digits];
        int        rem[Digits + 1];
        int        dv[Digits + 1];
        int        q[Digits + 2];
        int        m[Digits];
        int        za;
        int        zb;
        int        digit;
        int        start;
        int        v;
        int        borrow;
        bit        geq;
        bit        carry;
        longint    ea;
        longint    eb;
        longint    e;
        quotient_t r;
        for (int k = 0; k < Digits; k++)
        begin
            a[k] = digit_at(d.dividend.hi, d.dividend.lo, k);
            b[k] = digit_at(d.divisor.hi, d.divisor.lo, k);
        end
        za = 0;
        while (za < Digits && a[za] == 0) za++;
        zb = 0;
        while (zb < Digits && b[zb] == 0) zb++;
        r = '0;
        if (zb == Digits)
        begin
            r.status = STATUS_DIV_ZERO;
            return r;
        end
        r.neg = d.dividend.neg ^ d.divisor.neg;
        if (za == Digits)
        begin
            r.exp = 19'd1;
            r.status = STATUS_OK;
            return r;
        end
        ea = longint'(d.dividend.exp) - za;
        eb = longint'(d.divisor.exp) - zb;
        rem[0] = 0;
        dv[0] = 0;
        for (int k = 0; k < Digits; k++)
        begin
            rem[k + 1] = (k + za < Digits) ? a[k + za] : 0;
            dv[k + 1] = (k + zb < Digits) ? b[k + zb] : 0;
        end
        // one quotient digit per step, at most nine subtractions each
        for (int s = 0; s < Digits + 2; s++)
        begin
            digit = 0;
            forever
            begin
                if (digit >= 9) break;
                geq = 1'b1;
                for (int i = 0; i <= Digits; i++)
                begin
                    if (rem[i] != dv[i])
                    begin
                        geq = rem[i] > dv[i];
                        break;
                    end
                end
                if (!geq) break;
                borrow = 0;
                for (int i = Digits; i >= 0; i--)
                begin
                    v = rem[i] - dv[i] - borrow;
                    borrow = (v < 0) ? 1 : 0;
                    rem[i] = (v < 0) ? v + 10 : v;
                end
                digit++;
            end
            q[s] = digit;
            for (int i = 0; i < Digits; i++) rem[i] = rem[i + 1];
            rem[Digits] = 0;
        end
        // drop a leading zero digit, then round half up on the extra digit
        start = (q[0] == 0) ? 1 : 0;
        e = ea - eb + 1 - start;
        for (int k = 0; k < Digits; k++) m[k] = q[start + k];
        if (q[start + Digits] >= int'(RoundDigit))
        begin
            carry = 1'b1;
            for (int k = Digits - 1; k >= 0 && carry; k--)
            begin
                if (m[k] == 9) m[k] = 0;
                else
                begin
                    m[k]++;
                    carry = 1'b0;
                end
            end
            if (carry)
            begin
                m[0] = 1;
                e++;
            end
        end
        for (int k = 0; k < 15; k++)
        begin
            r.hi[(14 - k) * 4 +: 4] = m[k][3:0];
            r.lo[(14 - k) * 4 +: 4] = m[k + 15][3:0];
        end
        r.status = (e > ExpLimit || e < -ExpLimit) ? STATUS_RANGE : STATUS_OK;
        if (e > ExpFieldMax) e = ExpFieldMax;
        if (e < ExpFieldMin) e = ExpFieldMin;
        r.exp = e[18:0];
        return r;
    endfunction

    function automatic operand_t make_operand(logic neg, logic [59:0] hi, logic [59:0] lo,
                                              int exp);
        operand_t o;
        o.neg = neg;
        o.hi = hi;
        o.lo = lo;
        o.exp = exp[17:0];
        return o;
    endfunction

    // random decimal mantissa with the given number of leading zeros
    function automatic logic [119:0] random_mantissa(int zeros);
        logic [119:0] v;
        v = '0;
        for (int k = 0; k < Digits; k++)
        begin
            if (k < zeros) v[(29 - k) * 4 +: 4] = 4'd0;
            else if (k == zeros) v[(29 - k) * 4 +: 4] = 4'($urandom_range(9, 1));
            else v[(29 - k) * 4 +: 4] = 4'($urandom_range(9, 0));
        end
        return v;
    endfunction

    function automatic operand_t random_operand();
        operand_t     o;
        logic [119:0] man;
        int           kind;
        kind = $urandom_range(99);
        o.neg = 1'($urandom_range(1));
        if (kind < 70) man = random_mantissa(0);
        else if (kind < 85) man = random_mantissa($urandom_range(Digits - 1, 1));
        else if (kind < 95) man = 120'({$urandom, $urandom, $urandom, $urandom});
        else if (kind < 98) man = '0;
        else man = random_mantissa(Digits - 1);
        o.hi = man[119:60];
        o.lo = man[59:0];
        kind = $urandom_range(99);
        if (kind < 70) o.exp = 18'($signed($urandom_range(200)) - 100);
        else if (kind < 90) o.exp = 18'($signed($urandom_range(199998)) - 99999);
        else o.exp = 18'($urandom);
        return o;
    endfunction

    function automatic logic [InBytes*8-1:0] pack_division(division_t d);
        return {{(InBytes * 8 - InBits){1'b0}},
                d.divisor.exp, d.divisor.lo, d.divisor.hi, d.divisor.neg,
                d.dividend.exp, d.dividend.lo, d.dividend.hi, d.dividend.neg};
    endfunction

    // one division transfer on the input side, expectation queued on acceptance
    task automatic send_division(division_t d, bit known, quotient_t typed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_division(d);
        do @(posedge clk); while (!s_axis_tready);
        pending_quotients.push_back(known ? typed : divide_decimal(d));
    endtask

    function automatic void add_row(operand_t a, operand_t b, bit known, quotient_t res);
        stim_row_t row;
        row.in.dividend = a;
        row.in.divisor = b;
        row.known = known;
        row.res = res;
        directed_rows.push_back(row);
    endfunction

    // directed cases
    function automatic void build_directed_rows();
        logic [59:0] one;
        logic [59:0] nines;
        logic [59:0] effs;
        quotient_t   q;
        one = 60'h1 << 56;
        nines = 60'h999999999999999;
        effs = '1;
        // zero divisor
        q = '0;
        q.status = STATUS_DIV_ZERO;
        add_row(make_operand(1, one, 0, 5), make_operand(0, 0, 0, 3), 1, q);
        add_row(make_operand(0, 0, 0, 0), make_operand(1, 0, 0, -99999), 1, q);
        // zero dividend
        q = '0;
        q.neg = 1'b1;
        q.exp = 19'd1;
        q.status = STATUS_OK;
        add_row(make_operand(1, 0, 0, 77), make_operand(0, nines, nines, -8), 1, q);
        // one over one
        q = '0;
        q.hi = one;
        q.exp = 19'd1;
        q.status = STATUS_OK;
        add_row(make_operand(0, one, 0, 0), make_operand(0, one, 0, 0), 1, q);
        // exponent out of range both ways, and saturation of the field
        q.exp = 19'd100000;
        q.status = STATUS_RANGE;
        add_row(make_operand(0, one, 0, 99999), make_operand(0, one, 0, 0), 1, q);
        q.exp = 19'(-100000);
        add_row(make_operand(0, one, 0, 0), make_operand(0, one, 0, 100001), 1, q);
        add_row(make_operand(0, one, 0, 131071), make_operand(1, one, 0, -131072), 0, q);
        add_row(make_operand(1, one, 0, -131072), make_operand(0, one, 0, 131071), 0, q);
        add_row(make_operand(0, nines, nines, 99999), make_operand(0, one, 0, -99999), 0, q);
        // rounding carry, nibbles above nine, full-scale fields
        add_row(make_operand(0, nines, nines, 0), make_operand(0, one, 0, 0), 0, q);
        add_row(make_operand(1, effs, effs, -1), make_operand(1, effs, effs, 1), 0, q);
        add_row(make_operand(0, effs, effs, 0), make_operand(1, one, 1, 0), 0, q);
        // quotients below one so the first digit is zero, then one just above one
        add_row(make_operand(0, one, 0, 4), make_operand(0, 60'h3 << 56, 0, 2), 0, q);
        add_row(make_operand(0, one, 0, 0), make_operand(0, nines, nines, 0), 0, q);
        add_row(make_operand(1, one, 60'h1, 0), make_operand(0, one, 0, 0), 0, q);
        // unnormalized operands, then two normalized ones with a quotient below one
        add_row(make_operand(0, 0, 60'h7, 10), make_operand(0, 60'h3, 0, -10), 0, q);
        add_row(make_operand(1, 60'h000123, 60'h456, -5), make_operand(1, 0, 60'h1, 0), 0, q);
        add_row(make_operand(0, 60'h2 << 56, 0, 0), make_operand(0, 60'h7 << 56, 0, 0), 0, q);
    endfunction

    // receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // output transfer check against the oldest expectation
    always @(posedge clk)
    begin
        quotient_t got;
        quotient_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.neg = m_axis_tdata[0];
            got.hi = m_axis_tdata[60:1];
            got.lo = m_axis_tdata[120:61];
            got.exp = m_axis_tdata[139:121];
            got.status = status_t'(m_axis_tdata[141:140]);
            if (pending_quotients.size() == 0)
            begin
                $display("%0t: unexpected quotient %h", $realtime, got);
                error_count++;
            end
            else
            begin
                want = pending_quotients.pop_front();
                quotient_count++;
                if (want.status == STATUS_DIV_ZERO) div_zero_count++;
                if (want.status == STATUS_RANGE) range_count++;
                if (got.neg !== want.neg)
                begin
                    $display("%0t: sign expected %b got %b", $realtime, want.neg, got.neg);
                    error_count++;
                end
                if (got.hi !== want.hi)
                begin
                    $display("%0t: high digits expected %h got %h", $realtime, want.hi, got.hi);
                    error_count++;
                end
                if (got.lo !== want.lo)
                begin
                    $display("%0t: low digits expected %h got %h", $realtime, want.lo, got.lo);
                    error_count++;
                end
                if (got.exp !== want.exp)
                begin
                    $display("%0t: exponent expected %0d got %0d", $realtime,
                             $signed(want.exp), $signed(got.exp));
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %s got %0d", $realtime, want.status.name(),
                             m_axis_tdata[141:140]);
                    error_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        division_t d;
        quotient_t none;
        int        drain;
        none = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        quotient_count = 0;
        div_zero_count = 0;
        range_count = 0;
        build_directed_rows();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_division(directed_rows[i].in, directed_rows[i].known, directed_rows[i].res);
        // four idling phases over the random part
        for (int i = 0; i < RandomItems; i++)
        begin
            case (i / (RandomItems / 4))
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            d.dividend = random_operand();
            d.divisor = random_operand();
            send_division(d, 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_quotients.size() != 0) @(posedge clk);
        drain = 0;
        while (drain < 50)
        begin
            @(posedge clk);
            drain++;
        end
        $display("covered %0d divisions: %0d by zero, %0d out of exponent range",
                 quotient_count, div_zero_count, range_count);
        if (error_count == 0)
            $display("bcd_decimal_float_divider regression: pass");
        else
            $display("bcd_decimal_float_divider regression: fail");
        $finish;
    end

    // timeout
    initial
    begin
        #(64'd1_000_000_000);
        $display("timeout with %0d quotients outstanding", pending_quotients.size());
        $display("bcd_decimal_float_divider regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
